[rtl/bppb_pkg.sv]
// Shared types and constants of the path piece builder.
`default_nettype none

package bppb_pkg;

    // Command codes.
    localparam logic [2:0] OP_STRAIGHT = 3'd0;
    localparam logic [2:0] OP_TURN_L   = 3'd1;
    localparam logic [2:0] OP_TURN_R   = 3'd2;
    localparam logic [2:0] OP_SLALOM_L = 3'd3;
    localparam logic [2:0] OP_SLALOM_R = 3'd4;

    // Result status codes.
    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_NO_PREV   = 2'd1,
        ERR_ZERO_HEAD = 2'd2
    } err_t;

    // Arc constant and its complement, unsigned Q2.30.
    localparam logic [31:0] ARC_C = 32'd592614245;
    localparam logic [31:0] ARC_K = 32'd481127579;

    // Rounding shift applied by the multiply unit at the end of a product.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_30,
        SH_32
    } shift_t;

    typedef struct packed {
        logic   start;
        shift_t shift;
    } mac_ctl_t;

endpackage

`default_nettype wire

[rtl/bezier_path_piece_builder.sv]
// Top level of the path piece builder: command in, four Bezier control points out.
//
// Usage: the input channel (in_valid/in_stall) carries one path command per item:
// a straight, a left or right quarter turn, or a left or right slalom, starting at
// a given point and heading or at the end of the previous piece. The output
// channel (out_valid/out_stall) returns one item per command with the four
// control points p1..p4 (signed fixed point, saturated) and an error code.
// An item is taken at a rising edge where valid is high and stall is low.
// Operation: the block works on one item at a time and holds in_stall high
// meanwhile. A good command passes through heading normalization, two squares,
// an integer square root, one load and two restoring divisions, six or eight
// products, a summing step and a finishing step; the shared 16 x 32 multiplier
// and the bit-serial root and divide set how long this takes. A command with an
// error goes straight to the finishing step. The block returns to idle as it
// loads a result, so the next item can be taken in the following cycle.
// Reset clears the stored end point and tangent and marks that no piece exists
// yet. When the receiver stalls, the finished result waits in the output
// register and the block holds its last step until the register frees.
`default_nettype none

module bezier_path_piece_builder #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    op,
    input  wire logic                          use_given_start,
    input  wire logic signed [COORD_BITS-1:0]  start_x,
    input  wire logic signed [COORD_BITS-1:0]  start_y,
    input  wire logic signed [COORD_BITS-1:0]  heading_x,
    input  wire logic signed [COORD_BITS-1:0]  heading_y,
    input  wire logic [COORD_BITS-2:0]         amount,
    input  wire logic signed [COORD_BITS-1:0]  side_width,
    input  wire logic signed [COORD_BITS-1:0]  tangent_offset,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [COORD_BITS-1:0]       p1_x,
    output logic signed [COORD_BITS-1:0]       p1_y,
    output logic signed [COORD_BITS-1:0]       p2_x,
    output logic signed [COORD_BITS-1:0]       p2_y,
    output logic signed [COORD_BITS-1:0]       p3_x,
    output logic signed [COORD_BITS-1:0]       p3_y,
    output logic signed [COORD_BITS-1:0]       p4_x,
    output logic signed [COORD_BITS-1:0]       p4_y,
    output logic [1:0]                         error
);

    localparam int CB   = COORD_BITS;
    localparam int HW   = (CB > 30) ? CB : 30;
    localparam int AW   = (CB + 1 > 30) ? CB + 1 : 30;
    localparam int SW   = CB + 3;
    localparam int MPW  = ((AW + 15) / 16) * 16 + 32;

    localparam logic signed [SW-1:0] SMAX = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQX, S_SQY, S_SQRT, S_DIV_LD, S_DIVX, S_DIVY,
        S_PROD, S_CALC, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        K_STRAIGHT, K_TURN, K_SLALOM
    } kind_t;

    function automatic logic signed [CB-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [CB-1:0] r;
        if (v > SMAX)
            r = SMAX[CB-1:0];
        else if (v < SMIN)
            r = SMIN[CB-1:0];
        else
            r = v[CB-1:0];
        return r;
    endfunction

    state_t                  state_reg;
    kind_t                   kind_reg;
    logic                    left_reg;
    bppb_pkg::err_t          err_reg;
    logic signed [CB-1:0]    sx_reg, sy_reg, w_reg, f_reg;
    logic [CB-2:0]           amt_reg;
    logic [HW-1:0]           ax_reg, ay_reg;
    logic                    hxs_reg, hys_reg;
    logic [59:0]             sqx_reg;
    logic [61:0]             rad_reg;
    logic [30:0]             root_reg;
    logic [33:0]             rem_reg;
    logic [30:0]             num_reg;
    logic [4:0]              cnt_reg;
    logic [30:0]             uxm_reg, uym_reg;
    logic [2:0]              pidx_reg;
    logic                    issued_reg;
    logic signed [CB:0]      pr_reg [8];
    logic signed [CB-1:0]    pt_reg [8];
    logic signed [CB-1:0]    end_x_reg, end_y_reg, end_tx_reg, end_ty_reg;
    logic                    have_piece_reg;
    logic                    out_valid_reg;
    logic signed [CB-1:0]    out_p_reg [8];
    logic [1:0]              error_reg;

    // Heading selection and magnitude at accept.
    logic signed [CB-1:0]    hx_sel, hy_sel;
    logic [CB-1:0]           hx_abs, hy_abs;
    logic                    in_take;

    assign hx_sel  = use_given_start ? heading_x : end_tx_reg;
    assign hy_sel  = use_given_start ? heading_y : end_ty_reg;
    assign hx_abs  = hx_sel[CB-1] ? (~hx_sel + 1'b1) : hx_sel;
    assign hy_abs  = hy_sel[CB-1] ? (~hy_sel + 1'b1) : hy_sel;
    assign in_take = in_valid && !in_stall;

    // Normalization compare.
    logic [HW-1:0] mx;
    logic          mx_lo, mx_hi;

    assign mx    = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign mx_lo = mx < (HW'(1) << 29);
    assign mx_hi = {1'b0, mx} >= ((HW+1)'(1) << 30);

    // One step of the square root: two radicand bits a cycle.
    logic [33:0] r4, trial;
    logic        sq_ge;

    assign r4    = {rem_reg[31:0], rad_reg[61:60]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign sq_ge = r4 >= trial;

    // One step of the restoring divide.
    logic [31:0] r2, rdiff;
    logic        dv_ge;

    assign r2    = {rem_reg[30:0], num_reg[30]};
    assign rdiff = r2 - {1'b0, root_reg};
    assign dv_ge = r2 >= {1'b0, root_reg};

    // Operand selection for the shared multiplier.
    logic signed [CB+1:0]  amt_ext, amt3, a_val, a_abs;
    logic [31:0]           b_val;
    logic                  b_neg;
    bppb_pkg::shift_t      p_sh;
    logic [31:0]           uxb, uyb;

    assign amt_ext = signed'({3'b0, amt_reg});
    assign amt3    = amt_ext + {amt_ext[CB:0], 1'b0};
    assign uxb     = {1'b0, uxm_reg};
    assign uyb     = {1'b0, uym_reg};

    always_comb
    begin
        a_val = amt_ext;
        b_val = uxb;
        b_neg = hxs_reg;
        p_sh  = bppb_pkg::SH_30;
        case (kind_reg)
            K_TURN:
            begin
                case (pidx_reg)
                    3'd0: begin b_val = bppb_pkg::ARC_C; b_neg = 1'b0; end
                    3'd1: begin b_val = bppb_pkg::ARC_K; b_neg = 1'b0; end
                    3'd2: ;
                    3'd3: begin b_val = uyb; b_neg = hys_reg; end
                    3'd4: a_val = {pr_reg[0][CB], pr_reg[0]};
                    3'd5:
                    begin
                        a_val = {pr_reg[0][CB], pr_reg[0]};
                        b_val = uyb;
                        b_neg = hys_reg;
                    end
                    3'd6: a_val = {pr_reg[1][CB], pr_reg[1]};
                    default:
                    begin
                        a_val = {pr_reg[1][CB], pr_reg[1]};
                        b_val = uyb;
                        b_neg = hys_reg;
                    end
                endcase
            end
            K_SLALOM:
            begin
                case (pidx_reg)
                    3'd0: a_val = {{2{f_reg[CB-1]}}, f_reg};
                    3'd1:
                    begin
                        a_val = {{2{f_reg[CB-1]}}, f_reg};
                        b_val = uyb;
                        b_neg = hys_reg;
                    end
                    3'd2: ;
                    3'd3: begin b_val = uyb; b_neg = hys_reg; end
                    3'd4: a_val = {{2{w_reg[CB-1]}}, w_reg};
                    default:
                    begin
                        a_val = {{2{w_reg[CB-1]}}, w_reg};
                        b_val = uyb;
                        b_neg = hys_reg;
                    end
                endcase
            end
            default:
            begin
                // Quarter and three-quarter lengths come from the wider shift.
                case (pidx_reg)
                    3'd0: p_sh = bppb_pkg::SH_32;
                    3'd1: begin p_sh = bppb_pkg::SH_32; b_val = uyb; b_neg = hys_reg; end
                    3'd2: ;
                    3'd3: begin b_val = uyb; b_neg = hys_reg; end
                    3'd4: begin p_sh = bppb_pkg::SH_32; a_val = amt3; end
                    default:
                    begin
                        p_sh  = bppb_pkg::SH_32;
                        a_val = amt3;
                        b_val = uyb;
                        b_neg = hys_reg;
                    end
                endcase
            end
        endcase
    end

    assign a_abs = a_val[CB+1] ? -a_val : a_val;

    bppb_pkg::mac_ctl_t  mac_ctl;
    logic [AW-1:0]       mac_a;
    logic [31:0]         mac_b;
    logic                mac_done;
    logic [MPW-1:0]      mac_res;
    logic                mac_phase;

    assign mac_phase = (state_reg == S_SQX) || (state_reg == S_SQY) ||
                       (state_reg == S_PROD);
    assign mac_ctl   = '{start: mac_phase && !issued_reg,
                         shift: (state_reg == S_PROD) ? p_sh : bppb_pkg::SH_NONE};

    always_comb
    begin
        unique case (state_reg)
            S_SQX:
            begin
                mac_a = AW'(ax_reg[29:0]);
                mac_b = {2'b0, ax_reg[29:0]};
            end
            S_SQY:
            begin
                mac_a = AW'(ay_reg[29:0]);
                mac_b = {2'b0, ay_reg[29:0]};
            end
            default:
            begin
                mac_a = AW'(a_abs[CB:0]);
                mac_b = b_val;
            end
        endcase
    end

    bppb_mac #(
        .A_BITS (AW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a_mag (mac_a),
        .b_mag (mac_b),
        .done  (mac_done),
        .res   (mac_res)
    );

    // Signed product as stored; every product here fits one bit over a coordinate.
    logic [CB-1:0]       pmag;
    logic signed [CB:0]  pr_val;
    logic [2:0]          pidx_last;

    assign pmag      = mac_res[CB-1:0];
    assign pr_val    = (a_val[CB+1] ^ b_neg) ? -signed'({1'b0, pmag})
                                              : signed'({1'b0, pmag});
    assign pidx_last = (kind_reg == K_TURN) ? 3'd7 : 3'd5;

    // Sums of the control points.
    logic signed [SW-1:0]  sxe, sye, q [8];
    logic signed [SW-1:0]  bx, by, rtx, rty, atx, aty, wtx, wty;
    logic signed [CB-1:0]  ex_s, ey_s;
    logic signed [CB-1:0]  pcalc [8];

    always_comb
    begin
        sxe = SW'(sx_reg);
        sye = SW'(sy_reg);
        for (int i = 0; i < 8; i++)
            q[i] = SW'(pr_reg[i]);
        bx  = sxe + q[2];
        by  = sye + q[3];
        rtx = left_reg ? -q[7] : q[7];
        rty = left_reg ? q[6] : -q[6];
        atx = left_reg ? -q[3] : q[3];
        aty = left_reg ? q[2] : -q[2];
        wtx = left_reg ? -q[5] : q[5];
        wty = left_reg ? q[4] : -q[4];
        ex_s = sat(sxe + q[2] + wtx);
        ey_s = sat(sye + q[3] + wty);
        pcalc[0] = sx_reg;
        pcalc[1] = sy_reg;
        case (kind_reg)
            K_TURN:
            begin
                pcalc[2] = sat(sxe + q[4]);
                pcalc[3] = sat(sye + q[5]);
                pcalc[4] = sat(bx + rtx);
                pcalc[5] = sat(by + rty);
                pcalc[6] = sat(bx + atx);
                pcalc[7] = sat(by + aty);
            end
            K_SLALOM:
            begin
                pcalc[2] = sat(sxe + q[0]);
                pcalc[3] = sat(sye + q[1]);
                pcalc[4] = sat(SW'(ex_s) - q[0]);
                pcalc[5] = sat(SW'(ey_s) - q[1]);
                pcalc[6] = ex_s;
                pcalc[7] = ey_s;
            end
            default:
            begin
                pcalc[2] = sat(sxe + q[0]);
                pcalc[3] = sat(sye + q[1]);
                pcalc[4] = sat(sxe + q[4]);
                pcalc[5] = sat(sye + q[5]);
                pcalc[6] = sat(sxe + q[2]);
                pcalc[7] = sat(sye + q[3]);
            end
        endcase
    end

    // End tangent; halved when it does not fit, which keeps its direction.
    logic signed [SW-1:0]  dx, dy, dxs, dys;
    logic                  d_over;
    logic                  out_free;

    assign dx     = SW'(pt_reg[6]) - SW'(pt_reg[4]);
    assign dy     = SW'(pt_reg[7]) - SW'(pt_reg[5]);
    assign d_over = (dx > SMAX) || (dx < SMIN) || (dy > SMAX) || (dy < SMIN);
    assign dxs    = d_over ? (dx >>> 1) : dx;
    assign dys    = d_over ? (dy >>> 1) : dy;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_STRAIGHT;
            left_reg       <= 1'b0;
            err_reg        <= bppb_pkg::ERR_OK;
            sx_reg         <= '0;
            sy_reg         <= '0;
            w_reg          <= '0;
            f_reg          <= '0;
            amt_reg        <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            hxs_reg        <= 1'b0;
            hys_reg        <= 1'b0;
            sqx_reg        <= '0;
            rad_reg        <= '0;
            root_reg       <= '0;
            rem_reg        <= '0;
            num_reg        <= '0;
            cnt_reg        <= '0;
            uxm_reg        <= '0;
            uym_reg        <= '0;
            pidx_reg       <= '0;
            issued_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                pr_reg[i]    <= '0;
                pt_reg[i]    <= '0;
                out_p_reg[i] <= '0;
            end
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            end_tx_reg     <= '0;
            end_ty_reg     <= '0;
            have_piece_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_reg      <= '0;
        end
        else
        begin
            if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        sx_reg  <= use_given_start ? start_x : end_x_reg;
                        sy_reg  <= use_given_start ? start_y : end_y_reg;
                        w_reg   <= side_width;
                        f_reg   <= tangent_offset;
                        amt_reg <= amount;
                        ax_reg  <= HW'(hx_abs);
                        ay_reg  <= HW'(hy_abs);
                        hxs_reg <= hx_sel[CB-1];
                        hys_reg <= hy_sel[CB-1];
                        unique case (op) inside
                            bppb_pkg::OP_TURN_L, bppb_pkg::OP_TURN_R:
                                kind_reg <= K_TURN;
                            bppb_pkg::OP_SLALOM_L, bppb_pkg::OP_SLALOM_R:
                                kind_reg <= K_SLALOM;
                            default:
                                kind_reg <= K_STRAIGHT;
                        endcase
                        left_reg <= (op == bppb_pkg::OP_TURN_L) ||
                                    (op == bppb_pkg::OP_SLALOM_L);
                        if (!use_given_start && !have_piece_reg)
                        begin
                            err_reg   <= bppb_pkg::ERR_NO_PREV;
                            state_reg <= S_FIN;
                        end
                        else if (hx_sel == '0 && hy_sel == '0)
                        begin
                            err_reg   <= bppb_pkg::ERR_ZERO_HEAD;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            err_reg   <= bppb_pkg::ERR_OK;
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    if (mx_lo)
                    begin
                        ax_reg <= {ax_reg[HW-2:0], 1'b0};
                        ay_reg <= {ay_reg[HW-2:0], 1'b0};
                    end
                    else if (mx_hi)
                    begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                    end
                    else
                    begin
                        issued_reg <= 1'b0;
                        state_reg  <= S_SQX;
                    end
                end
                S_SQX:
                begin
                    if (!issued_reg)
                        issued_reg <= 1'b1;
                    if (mac_done)
                    begin
                        sqx_reg    <= mac_res[59:0];
                        issued_reg <= 1'b0;
                        state_reg  <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    if (!issued_reg)
                        issued_reg <= 1'b1;
                    if (mac_done)
                    begin
                        rad_reg    <= 62'(sqx_reg) + 62'(mac_res[59:0]);
                        issued_reg <= 1'b0;
                        root_reg   <= '0;
                        rem_reg    <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    rad_reg <= {rad_reg[59:0], 2'b00};
                    if (sq_ge)
                    begin
                        rem_reg  <= r4 - trial;
                        root_reg <= {root_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= r4;
                        root_reg <= {root_reg[29:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd30)
                        state_reg <= S_DIV_LD;
                end
                S_DIV_LD:
                begin
                    // Numerator is the component times 2^30 plus half the norm.
                    rem_reg   <= 34'(ax_reg[29:1]);
                    num_reg   <= {ax_reg[0], root_reg[30:1]};
                    cnt_reg   <= '0;
                    state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    rem_reg <= dv_ge ? 34'(rdiff[30:0]) : 34'(r2[30:0]);
                    num_reg <= {num_reg[29:0], 1'b0};
                    uxm_reg <= {uxm_reg[29:0], dv_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd30)
                    begin
                        rem_reg   <= 34'(ay_reg[29:1]);
                        num_reg   <= {ay_reg[0], root_reg[30:1]};
                        cnt_reg   <= '0;
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    rem_reg <= dv_ge ? 34'(rdiff[30:0]) : 34'(r2[30:0]);
                    num_reg <= {num_reg[29:0], 1'b0};
                    uym_reg <= {uym_reg[29:0], dv_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd30)
                    begin
                        pidx_reg   <= '0;
                        issued_reg <= 1'b0;
                        state_reg  <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    if (!issued_reg)
                        issued_reg <= 1'b1;
                    if (mac_done)
                    begin
                        pr_reg[pidx_reg] <= pr_val;
                        issued_reg       <= 1'b0;
                        pidx_reg         <= pidx_reg + 1'b1;
                        if (pidx_reg == pidx_last)
                            state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    for (int i = 0; i < 8; i++)
                        pt_reg[i] <= pcalc[i];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        error_reg     <= err_reg;
                        if (err_reg == bppb_pkg::ERR_OK)
                        begin
                            for (int i = 0; i < 8; i++)
                                out_p_reg[i] <= pt_reg[i];
                            end_x_reg      <= pt_reg[6];
                            end_y_reg      <= pt_reg[7];
                            end_tx_reg     <= dxs[CB-1:0];
                            end_ty_reg     <= dys[CB-1:0];
                            have_piece_reg <= 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < 8; i++)
                                out_p_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign p1_x      = out_p_reg[0];
    assign p1_y      = out_p_reg[1];
    assign p2_x      = out_p_reg[2];
    assign p2_y      = out_p_reg[3];
    assign p3_x      = out_p_reg[4];
    assign p3_y      = out_p_reg[5];
    assign p4_x      = out_p_reg[6];
    assign p4_y      = out_p_reg[7];
    assign error     = error_reg;

    // A new result is only loaded from the finishing step.
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside the finishing step");

    // A failed command reports all points as zero; the check covers p1 and p4.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg != bppb_pkg::ERR_OK) |->
        (p1_x == '0 && p1_y == '0 && p4_x == '0 && p4_y == '0))
        else $error("error result carries nonzero points");

    // Once a piece exists it is never forgotten.
    a_piece_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(have_piece_reg))
        else $error("previous piece lost");

    // An accepted item starts work at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg != S_IDLE))
        else $error("accepted item dropped");

    // A result waiting under stall is not overwritten.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(error_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[rtl/bppb_mac.sv]
// Shared multi-cycle multiplier: 16 by 32 bits a cycle, then a rounding shift.
`default_nettype none

module bppb_mac #(
    parameter int A_BITS = 30
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bppb_pkg::mac_ctl_t                 ctl,
    input  wire logic [A_BITS-1:0]                  a_mag,
    input  wire logic [31:0]                        b_mag,
    output logic                                    done,
    output logic [((A_BITS+15)/16)*16+32-1:0]       res
);

    localparam int NCH  = (A_BITS + 15) / 16;
    localparam int PADW = NCH * 16;
    localparam int PW   = PADW + 32;
    localparam int CW   = $clog2(NCH + 1);

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [PADW-1:0]     a_reg;
    logic [31:0]         b_reg;
    logic [PW-1:0]       acc_reg;
    bppb_pkg::shift_t    sh_reg;
    logic                done_reg;
    logic [PW-1:0]       res_reg;

    logic [47:0]         part;
    logic [PW-1:0]       acc_next;
    logic [PW:0]         rnd;
    logic [PW:0]         rnd_sum;
    logic [PW-1:0]       res_next;

    // Most significant chunk first, so the running sum only shifts left.
    assign part     = a_reg[PADW-1 -: 16] * b_reg;
    assign acc_next = {acc_reg[PW-17:0], 16'b0} + PW'(part);

    always_comb
    begin
        case (sh_reg)
            bppb_pkg::SH_30: rnd = (PW+1)'(1) << 29;
            bppb_pkg::SH_32: rnd = (PW+1)'(1) << 31;
            default:         rnd = '0;
        endcase
        rnd_sum = {1'b0, acc_reg} + rnd;
        case (sh_reg)
            bppb_pkg::SH_30: res_next = PW'(rnd_sum >> 30);
            bppb_pkg::SH_32: res_next = PW'(rnd_sum >> 32);
            default:         res_next = rnd_sum[PW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            sh_reg   <= bppb_pkg::SH_NONE;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (ctl.start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    a_reg    <= PADW'(a_mag);
                    b_reg    <= b_mag;
                    acc_reg  <= '0;
                    sh_reg   <= ctl.shift;
                end
            end
            else if (cnt_reg != CW'(NCH))
            begin
                acc_reg <= acc_next;
                a_reg   <= {a_reg[PADW-17:0], 16'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                res_reg  <= res_next;
                done_reg <= 1'b1;
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

[test/bppb_checker.sv]
// Checker for the path piece builder: predicts each command's control points and compares.
`default_nettype none

module bppb_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [2:0]         op,
    input  wire logic               use_given_start,
    input  wire logic signed [23:0] start_x,
    input  wire logic signed [23:0] start_y,
    input  wire logic signed [23:0] heading_x,
    input  wire logic signed [23:0] heading_y,
    input  wire logic [22:0]        amount,
    input  wire logic signed [23:0] side_width,
    input  wire logic signed [23:0] tangent_offset,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [23:0] p1_x,
    input  wire logic signed [23:0] p1_y,
    input  wire logic signed [23:0] p2_x,
    input  wire logic signed [23:0] p2_y,
    input  wire logic signed [23:0] p3_x,
    input  wire logic signed [23:0] p3_y,
    input  wire logic signed [23:0] p4_x,
    input  wire logic signed [23:0] p4_y,
    input  wire logic [1:0]         error,
    output int                      fail_count,
    output int                      pending
);

    localparam longint CMAX = 64'sd8388607;
    localparam longint CMIN = -64'sd8388608;

    typedef struct {
        logic signed [23:0] pt [8];
        bppb_pkg::err_t     status;
    } piece_t;

    piece_t piece_q [$];

    longint end_px, end_py, end_tx, end_ty;
    bit     have_piece;

    function automatic longint clamp(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    // Product scaled down by 2^s with rounding half away from zero.
    function automatic longint scale_mul(longint a, longint b, int s);
        longint ua, ub, hi, lo, r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        hi = ua >>> s;
        lo = ua & ((64'sd1 <<< s) - 1);
        r = hi * ub + ((lo * ub + (64'sd1 <<< (s - 1))) >>> s);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    // Unit heading in Q2.30; returns 0 on a zero vector.
    function automatic bit unit_heading(longint hx, longint hy, output longint ux,
                                        output longint uy);
        longint ax, ay, mx, n;
        ax = (hx < 0) ? -hx : hx;
        ay = (hy < 0) ? -hy : hy;
        mx = (ax > ay) ? ax : ay;
        ux = 0;
        uy = 0;
        if (mx == 0) return 0;
        while (mx < (64'sd1 <<< 29)) begin ax = ax <<< 1; ay = ay <<< 1; mx = mx <<< 1; end
        while (mx >= (64'sd1 <<< 30)) begin ax = ax >>> 1; ay = ay >>> 1; mx = mx >>> 1; end
        n = int_sqrt(ax * ax + ay * ay);
        ax = ((ax <<< 30) + n / 2) / n;
        ay = ((ay <<< 30) + n / 2) / n;
        ux = (hx < 0) ? -ax : ax;
        uy = (hy < 0) ? -ay : ay;
        return 1;
    endfunction

    function automatic longint half_floor(longint v);
        return v >>> 1;
    endfunction

    task automatic predict_piece();
        piece_t res;
        longint sx, sy, hx, hy, ux, uy, tx, ty, amt, dx, dy;
        longint rc, rk, bx, by, w, f, fx, fy, ex, ey;
        longint p [8];
        res.status = bppb_pkg::ERR_OK;
        amt = longint'(amount);
        if (use_given_start)
        begin
            sx = start_x; sy = start_y; hx = heading_x; hy = heading_y;
        end
        else
        begin
            sx = end_px; sy = end_py; hx = end_tx; hy = end_ty;
            if (!have_piece) res.status = bppb_pkg::ERR_NO_PREV;
        end
        if (res.status == bppb_pkg::ERR_OK && !unit_heading(hx, hy, ux, uy))
            res.status = bppb_pkg::ERR_ZERO_HEAD;
        if (res.status != bppb_pkg::ERR_OK)
        begin
            foreach (res.pt[i]) res.pt[i] = '0;
            piece_q.insert(piece_q.size(), res);
            return;
        end
        if (op == bppb_pkg::OP_TURN_L || op == bppb_pkg::OP_SLALOM_L)
        begin
            tx = -uy; ty = ux;
        end
        else
        begin
            tx = uy; ty = -ux;
        end
        p[0] = sx; p[1] = sy;
        if (op == bppb_pkg::OP_TURN_L || op == bppb_pkg::OP_TURN_R)
        begin
            rc = scale_mul(amt, longint'(bppb_pkg::ARC_C), 30);
            rk = scale_mul(amt, longint'(bppb_pkg::ARC_K), 30);
            bx = sx + scale_mul(amt, ux, 30);
            by = sy + scale_mul(amt, uy, 30);
            p[2] = sx + scale_mul(rc, ux, 30); p[3] = sy + scale_mul(rc, uy, 30);
            p[4] = bx + scale_mul(rk, tx, 30); p[5] = by + scale_mul(rk, ty, 30);
            p[6] = bx + scale_mul(amt, tx, 30); p[7] = by + scale_mul(amt, ty, 30);
        end
        else if (op == bppb_pkg::OP_SLALOM_L || op == bppb_pkg::OP_SLALOM_R)
        begin
            w = side_width; f = tangent_offset;
            fx = scale_mul(f, ux, 30); fy = scale_mul(f, uy, 30);
            ex = clamp(sx + scale_mul(amt, ux, 30) + scale_mul(w, tx, 30));
            ey = clamp(sy + scale_mul(amt, uy, 30) + scale_mul(w, ty, 30));
            p[2] = sx + fx; p[3] = sy + fy;
            p[4] = ex - fx; p[5] = ey - fy;
            p[6] = ex; p[7] = ey;
        end
        else
        begin
            // Straight; the unused codes fall here too.
            p[2] = sx + scale_mul(amt, ux, 32); p[3] = sy + scale_mul(amt, uy, 32);
            p[4] = sx + scale_mul(3 * amt, ux, 32); p[5] = sy + scale_mul(3 * amt, uy, 32);
            p[6] = sx + scale_mul(amt, ux, 30); p[7] = sy + scale_mul(amt, uy, 30);
        end
        for (int i = 0; i < 8; i++)
        begin
            p[i] = clamp(p[i]);
            res.pt[i] = p[i][23:0];
        end
        dx = p[6] - p[4];
        dy = p[7] - p[5];
        if (dx > CMAX || dx < CMIN || dy > CMAX || dy < CMIN)
        begin
            dx = half_floor(dx);
            dy = half_floor(dy);
        end
        end_px = p[6]; end_py = p[7]; end_tx = dx; end_ty = dy;
        have_piece = 1;
        piece_q.insert(piece_q.size(), res);
    endtask

    task automatic check_piece();
        piece_t exp_piece;
        logic signed [23:0] got [8];
        string names [8];
        names = '{"p1_x", "p1_y", "p2_x", "p2_y", "p3_x", "p3_y", "p4_x", "p4_y"};
        got = '{p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y};
        if (piece_q.size() == 0)
        begin
            $error("result item with no command waiting");
            fail_count++;
            return;
        end
        exp_piece = piece_q.pop_front();
        for (int i = 0; i < 8; i++)
            if (got[i] !== exp_piece.pt[i])
            begin
                $error("%s: expected %0d, got %0d", names[i], exp_piece.pt[i], got[i]);
                fail_count++;
            end
        if (error !== exp_piece.status)
        begin
            $error("error: expected %0d, got %0d", exp_piece.status, error);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        end_px = 0; end_py = 0; end_tx = 0; end_ty = 0;
        have_piece = 0;
    end

    assign pending = piece_q.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) check_piece();
            if (in_valid && !in_stall) predict_piece();
        end
    end

endmodule

`default_nettype wire

[test/tb_bezier_path_piece_builder.sv]
// Testbench top for the path piece builder: stimulus, receiver stalls and verdict.
`default_nettype none

module tb_bezier_path_piece_builder;

    // The block is serial and slow, so the stimulus stays near 1300 commands
    // to keep the run short even with the random gaps on both sides.
    localparam int RANDOM_ITEMS = 1280;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         op;
    logic               use_given_start;
    logic signed [23:0] start_x, start_y, heading_x, heading_y;
    logic [22:0]        amount;
    logic signed [23:0] side_width, tangent_offset;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y;
    logic [1:0]         error;
    int                 fail_count;
    int                 pending;

    // Receiver behavior: with idle_on clear the receiver stalls only for hold_cycles;
    // hold_cycles forces one long stall so the block backs up into its input.
    bit idle_on;
    int hold_cycles;

    bezier_path_piece_builder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .use_given_start(use_given_start),
        .start_x(start_x), .start_y(start_y),
        .heading_x(heading_x), .heading_y(heading_y),
        .amount(amount), .side_width(side_width), .tangent_offset(tangent_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
        .p3_x(p3_x), .p3_y(p3_y), .p4_x(p4_x), .p4_y(p4_y),
        .error(error)
    );

    bppb_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .use_given_start(use_given_start),
        .start_x(start_x), .start_y(start_y),
        .heading_x(heading_x), .heading_y(heading_y),
        .amount(amount), .side_width(side_width), .tangent_offset(tangent_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
        .p3_x(p3_x), .p3_y(p3_y), .p4_x(p4_x), .p4_y(p4_y),
        .error(error),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // A random coordinate: mostly moderate, sometimes the full range or an extreme.
    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2, 3:    return 24'($urandom);
            default: return $signed(24'($urandom_range(0, 2 * 65536 * 4))) - 24'sd524288;
        endcase
    endfunction

    function automatic logic [22:0] rand_amount();
        case ($urandom_range(0, 9))
            0:       return 23'h7FFFFF;
            1:       return 23'd0;
            2:       return 23'($urandom);
            default: return 23'($urandom_range(0, 65536 * 6));
        endcase
    endfunction

    // Offer one command and hold it until the block accepts it. The valid
    // is only lowered after acceptance when the next command comes after a gap.
    task automatic send_cmd(input logic [2:0] c_op, input logic c_given,
                            input logic signed [23:0] sx, input logic signed [23:0] sy,
                            input logic signed [23:0] hx, input logic signed [23:0] hy,
                            input logic [22:0] amt, input logic signed [23:0] w,
                            input logic signed [23:0] f);
        while (idle_on && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        op              <= c_op;
        use_given_start <= c_given;
        start_x         <= sx;
        start_y         <= sy;
        heading_x       <= hx;
        heading_y       <= hy;
        amount          <= amt;
        side_width      <= w;
        tangent_offset  <= f;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random();
        logic [2:0] c_op;
        logic       c_given;
        logic signed [23:0] hx, hy;
        // Mostly real commands; unused codes and chained starts mixed in.
        c_op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        c_given = ($urandom_range(0, 2) == 0);
        hx = rand_coord();
        hy = rand_coord();
        if ($urandom_range(0, 39) == 0)
        begin
            hx = '0;
            hy = '0;
        end
        send_cmd(c_op, c_given, rand_coord(), rand_coord(), hx, hy,
                 rand_amount(), rand_coord(), rand_coord());
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_on && ($urandom_range(0, 99) < 36);
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = bppb_pkg::OP_STRAIGHT;
        use_given_start = 1'b0;
        start_x = '0; start_y = '0; heading_x = '0; heading_y = '0;
        amount = '0; side_width = '0; tangent_offset = '0;
        idle_on = 1'b0;
        hold_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: chaining before any piece, zero heading, every op, extremes.
        send_cmd(bppb_pkg::OP_STRAIGHT, 1'b0, 0, 0, 0, 0, 23'd65536, 0, 0);
        send_cmd(bppb_pkg::OP_TURN_L, 1'b1, 0, 0, 0, 0, 23'd65536, 0, 0);
        send_cmd(bppb_pkg::OP_STRAIGHT, 1'b1, 0, 0, 24'sd65536, 0, 23'd131072, 0, 0);
        send_cmd(bppb_pkg::OP_TURN_L, 1'b0, 0, 0, 0, 0, 23'd65536, 0, 0);
        send_cmd(bppb_pkg::OP_TURN_R, 1'b0, 0, 0, 0, 0, 23'd65536, 0, 0);
        send_cmd(bppb_pkg::OP_SLALOM_L, 1'b0, 0, 0, 0, 0, 23'd131072, 24'sd32768,
                 24'sd40000);
        send_cmd(bppb_pkg::OP_SLALOM_R, 1'b0, 0, 0, 0, 0, 23'd131072, -24'sd32768,
                 -24'sd40000);
        send_cmd(3'd5, 1'b1, 24'sd100, -24'sd100, -24'sd3, 24'sd4, 23'd65536, 0, 0);
        send_cmd(3'd6, 1'b0, 0, 0, 0, 0, 23'd1, 0, 0);
        send_cmd(3'd7, 1'b0, 0, 0, 0, 0, 23'h7FFFFF, 0, 0);
        send_cmd(bppb_pkg::OP_STRAIGHT, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                 24'sh7FFFFF, 23'h7FFFFF, 0, 0);
        send_cmd(bppb_pkg::OP_TURN_L, 1'b1, 24'sh800000, 24'sh800000, 24'sh800000,
                 24'sh800000, 23'h7FFFFF, 0, 0);
        send_cmd(bppb_pkg::OP_TURN_R, 1'b1, 24'sh7FFFFF, 24'sh800000, 24'sd1, 0,
                 23'h7FFFFF, 0, 0);
        // Large slaloms overflow the end tangent, which must then be halved.
        send_cmd(bppb_pkg::OP_SLALOM_L, 1'b1, 24'sh800000, 24'sh7FFFFF, 0, -24'sd1,
                 23'h7FFFFF, 24'sh7FFFFF, 24'sh800000);
        send_cmd(bppb_pkg::OP_SLALOM_R, 1'b0, 0, 0, 0, 0, 23'h7FFFFF, 24'sh800000,
                 24'sh7FFFFF);
        send_cmd(bppb_pkg::OP_STRAIGHT, 1'b0, 0, 0, 0, 0, 23'd0, 0, 0);
        send_cmd(bppb_pkg::OP_SLALOM_L, 1'b1, 0, 0, 24'sh555555, -24'sh2AAAAA,
                 23'h2AAAAA, 24'sh555555, -24'sh555555);
        send_cmd(bppb_pkg::OP_STRAIGHT, 1'b1, 0, 0, 0, 0, 23'd65536, 0, 0);

        // Random part with idling on both sides; a quiet stretch in the middle.
        idle_on = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200) hold_cycles = 800;
            if (i == 500) idle_on = 1'b0;
            if (i == 700) idle_on = 1'b1;
            send_random();
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
